// ----- rtl/core/wsd_pkg.sv -----
// shared types and constants of the websocket frame deframer
package wsd_pkg;

  // parse phase of the incoming byte stream
  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_DATA = 3'd4
  } wsd_phase_t;

  // result event codes
  localparam logic [1:0] EV_DATA  = 2'd0;
  localparam logic [1:0] EV_EMPTY = 2'd1;
  localparam logic [1:0] EV_ERR   = 2'd2;

  // header codes
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [2:0] EXT16_CNT = 3'd1;
  localparam logic [2:0] EXT64_CNT = 3'd7;
  localparam logic [2:0] MASK_CNT  = 3'd3;

  // one result item
  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  payload_byte;
    logic [3:0]  frame_opcode;
    logic [3:0]  message_opcode;
    logic        frame_last;
    logic        message_done;
    logic        close_seen;
    logic [15:0] close_status;
  } wsd_result_t;

  // parser output toward the result register
  typedef struct packed {
    logic        valid;
    wsd_result_t res;
  } wsd_res_t;

endpackage

// ----- rtl/core/wsd_if.sv -----
// valid/ready channel interfaces for the byte input and the result output
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [7:0]  payload_byte;
  logic [3:0]  frame_opcode;
  logic [3:0]  message_opcode;
  logic        frame_last;
  logic        message_done;
  logic        close_seen;
  logic [15:0] close_status;

  modport source (output valid, output event_res, output payload_byte,
                  output frame_opcode, output message_opcode, output frame_last,
                  output message_done, output close_seen, output close_status,
                  input ready);
  modport sink   (input valid, input event_res, input payload_byte,
                  input frame_opcode, input message_opcode, input frame_last,
                  input message_done, input close_seen, input close_status,
                  output ready);
endinterface

// ----- rtl/core/websocket_frame_deframer_core.sv -----
// top level of the websocket frame deframer: parser and result register
//
//   channel   dir  handshake     payload
//   in_ch     in   valid/ready   rx_byte
//   out_ch    out  valid/ready   event_res, payload_byte, opcodes, flags, close_status
//
// one byte is taken every clock while the result register is empty or being
// drained, so an output stall holds input only once a result is waiting. a
// byte's result, if any, shows in the next cycle from the result register;
// header and mask bytes give none but an unmasked-frame error or empty frame.
// rst_n is synchronous; after reset the parser waits for a first header byte.
module websocket_frame_deframer_core (
  input  logic clk,
  input  logic rst_n,
  wsd_in_if.sink    in_ch,
  wsd_out_if.source out_ch
);
  import wsd_pkg::*;

  logic        in_fire;
  wsd_res_t    res;
  logic        out_valid_r;
  wsd_result_t out_res_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  wsd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (in_fire),
    .byte_data (in_ch.rx_byte),
    .res_o     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res.valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res.valid) begin
      out_res_r <= res.res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.event_res      = out_res_r.event_res;
  assign out_ch.payload_byte   = out_res_r.payload_byte;
  assign out_ch.frame_opcode   = out_res_r.frame_opcode;
  assign out_ch.message_opcode = out_res_r.message_opcode;
  assign out_ch.frame_last     = out_res_r.frame_last;
  assign out_ch.message_done   = out_res_r.message_done;
  assign out_ch.close_seen     = out_res_r.close_seen;
  assign out_ch.close_status   = out_res_r.close_status;

  // checks
  a_res_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> in_fire)
    else $error("parser result without a byte transfer");

  a_res_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && res.valid |=> out_valid_r)
    else $error("parser result not captured");

  a_err_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.event_res == EV_ERR) |->
      !out_res_r.frame_last && !out_res_r.message_done && !out_res_r.close_seen)
    else $error("protocol error carries frame end flags");

  a_done_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.message_done || out_res_r.close_seen) |->
      out_res_r.frame_last && !(out_res_r.message_done && out_res_r.close_seen))
    else $error("inconsistent frame end flags");

endmodule

// ----- rtl/core/wsd_parser.sv -----
// frame header parser, payload unmasking and message tracking
module wsd_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            byte_fire,
  input  logic [7:0]      byte_data,
  output wsd_pkg::wsd_res_t res_o
);
  import wsd_pkg::*;

  wsd_phase_t  phase_r, phase_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  midx_r, midx_nxt;
  logic [1:0]  seen_r, seen_nxt;
  logic        frag_r, frag_nxt;
  logic [3:0]  held_r, held_nxt;
  logic [15:0] status_r, status_nxt;
  logic        stopped_r, stopped_nxt;

  logic [3:0]  fop;
  logic        fin;
  logic        is_frag;
  logic [7:0]  key_byte;
  logic [7:0]  plain;
  logic        end_frame;

  assign fop     = flags_r[3:0];
  assign fin     = flags_r[7];
  assign is_frag = !fin || (fop == OP_CONT);

  // mask byte for the current payload position, first key byte in the top bits
  always_comb begin
    case (midx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end
  assign plain = byte_data ^ key_byte;

  // next state and result for one accepted byte
  always_comb begin
    phase_nxt   = phase_r;
    flags_nxt   = flags_r;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    key_nxt     = key_r;
    midx_nxt    = midx_r;
    seen_nxt    = seen_r;
    frag_nxt    = frag_r;
    held_nxt    = held_r;
    status_nxt  = status_r;
    stopped_nxt = stopped_r;
    end_frame   = 1'b0;
    res_o       = '0;

    if (byte_fire && !stopped_r) begin
      unique case (phase_r)
        PH_HDR0: begin
          flags_nxt = byte_data;
          phase_nxt = PH_HDR1;
        end
        PH_HDR1: begin
          if (!byte_data[7]) begin
            // unmasked frame is a protocol error, block goes dead
            res_o.valid              = 1'b1;
            res_o.res.event_res      = EV_ERR;
            res_o.res.frame_opcode   = fop;
            res_o.res.message_opcode = fop;
            stopped_nxt              = 1'b1;
          end else if (byte_data[6:0] == LEN_EXT16) begin
            rem_nxt   = '0;
            cnt_nxt   = EXT16_CNT;
            phase_nxt = PH_EXT;
          end else if (byte_data[6:0] == LEN_EXT64) begin
            rem_nxt   = '0;
            cnt_nxt   = EXT64_CNT;
            phase_nxt = PH_EXT;
          end else begin
            rem_nxt   = {57'd0, byte_data[6:0]};
            cnt_nxt   = MASK_CNT;
            phase_nxt = PH_MASK;
          end
        end
        PH_EXT: begin
          rem_nxt = {rem_r[55:0], byte_data};
          if (cnt_r == 3'd0) begin
            cnt_nxt   = MASK_CNT;
            phase_nxt = PH_MASK;
          end else begin
            cnt_nxt = cnt_r - 3'd1;
          end
        end
        PH_MASK: begin
          key_nxt = {key_r[23:0], byte_data};
          if (cnt_r != 3'd0) begin
            cnt_nxt = cnt_r - 3'd1;
          end else begin
            // last mask byte: the frame starts
            midx_nxt   = 2'd0;
            seen_nxt   = 2'd0;
            status_nxt = '0;
            if (is_frag && !frag_r) begin
              frag_nxt = 1'b1;
              held_nxt = fop;
            end
            if (rem_r == 64'd0) begin
              res_o.valid              = 1'b1;
              res_o.res.event_res      = EV_EMPTY;
              res_o.res.frame_opcode   = fop;
              res_o.res.message_opcode = is_frag ? held_nxt : fop;
              end_frame                = 1'b1;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          midx_nxt = midx_r + 2'd1;
          if (seen_r < 2'd2) begin
            status_nxt = {status_r[7:0], plain};
            seen_nxt   = seen_r + 2'd1;
          end
          rem_nxt                  = rem_r - 64'd1;
          res_o.valid              = 1'b1;
          res_o.res.event_res      = EV_DATA;
          res_o.res.payload_byte   = plain;
          res_o.res.frame_opcode   = fop;
          res_o.res.message_opcode = is_frag ? held_r : fop;
          end_frame                = (rem_r == 64'd1);
        end
        default: begin
          phase_nxt = PH_HDR0;
        end
      endcase

      // frame end flags and return to header parsing
      if (end_frame) begin
        res_o.res.frame_last = 1'b1;
        if (fop == OP_CLOSE) begin
          res_o.res.close_seen   = 1'b1;
          res_o.res.close_status = (seen_nxt >= 2'd2) ? status_nxt : 16'd0;
          stopped_nxt            = 1'b1;
        end else if (fin) begin
          res_o.res.message_done = 1'b1;
          frag_nxt               = 1'b0;
        end
        phase_nxt = PH_HDR0;
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR0;
      flags_r   <= '0;
      cnt_r     <= '0;
      rem_r     <= '0;
      key_r     <= '0;
      midx_r    <= '0;
      seen_r    <= '0;
      frag_r    <= 1'b0;
      held_r    <= '0;
      status_r  <= '0;
      stopped_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      flags_r   <= flags_nxt;
      cnt_r     <= cnt_nxt;
      rem_r     <= rem_nxt;
      key_r     <= key_nxt;
      midx_r    <= midx_nxt;
      seen_r    <= seen_nxt;
      frag_r    <= frag_nxt;
      held_r    <= held_nxt;
      status_r  <= status_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule
